@@ src/max_tracking_stack_defines.svh @@
// -----------------------------------------------------------------------------
// max tracking stack assertion macros
// shared assertion forms for the port checker
// -----------------------------------------------------------------------------
`ifndef MAX_TRACKING_STACK_DEFINES_SVH
`define MAX_TRACKING_STACK_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MTS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("max tracking stack check failed");

// next-cycle implication, disabled in reset
`define MTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("max tracking stack check failed");

`endif

@@ src/mts_pkg.sv @@
// -----------------------------------------------------------------------------
// mts_pkg
// shared types and constants of the max tracking stack
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mts_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [1:0] FUNC_PUSH   = 2'd0;
  localparam logic [1:0] FUNC_POP    = 2'd1;
  localparam logic [1:0] FUNC_POPMAX = 2'd2;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HUNT,
    ST_FIX
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP,
    OP_ARM,
    OP_HUNT,
    OP_FIX
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     hit;
  } cell_ctl_t;

endpackage

@@ src/mts_cell.sv @@
// -----------------------------------------------------------------------------
// mts_cell
// one stack slot: value, maximum of itself and all below, hunt token
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mts_cell #(
  parameter int VALUE_WIDTH = 32,
  parameter int IDX_W       = 4,
  parameter int IDX         = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mts_pkg::cell_ctl_t     ctl,
  input  logic [IDX_W-1:0]       last_idx,
  input  logic [VALUE_WIDTH-1:0] target,
  input  logic [VALUE_WIDTH-1:0] above_val,
  input  logic [VALUE_WIDTH-1:0] above_max,
  input  logic [VALUE_WIDTH-1:0] below_val,
  input  logic [VALUE_WIDTH-1:0] below_max,
  input  logic                   tok_above,
  output logic [VALUE_WIDTH-1:0] val,
  output logic [VALUE_WIDTH-1:0] max,
  output logic                   tok,
  output logic                   hit
);
  import mts_pkg::*;

  logic                   seen;
  logic                   is_bottom;
  logic [VALUE_WIDTH-1:0] fix_max;

  assign hit       = tok && (val == target);
  assign is_bottom = (IDX_W'(IDX) == last_idx);
  assign fix_max   = (is_bottom || $signed(val) >= $signed(below_max)) ? val : below_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok  <= 1'b0;
      seen <= 1'b0;
    end else begin
      unique case (ctl.op)
        OP_ARM: begin
          tok  <= (IDX == 0);
          seen <= 1'b0;
        end
        OP_HUNT: begin
          if (ctl.hit) begin
            tok <= 1'b0;
          end else begin
            tok  <= tok_above;
            seen <= seen | tok;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_PUSH: begin
        val <= above_val;
        max <= above_max;
      end
      OP_POP: begin
        val <= below_val;
        max <= below_max;
      end
      OP_HUNT: begin
        if (ctl.hit && !seen) begin
          val <= below_val;
          max <= below_max;
        end
      end
      OP_FIX: begin
        max <= fix_max;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ src/mts_ctrl.sv @@
// -----------------------------------------------------------------------------
// mts_ctrl
// request sequencing, entry count and result registers
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mts_ctrl #(
  parameter int STACK_DEPTH = 16,
  parameter int VALUE_WIDTH = 32,
  parameter int CNT_W       = 5,
  parameter int IDX_W       = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [1:0]             func,
  input  logic [VALUE_WIDTH-1:0] push_val,
  input  logic [VALUE_WIDTH-1:0] top_val,
  input  logic [VALUE_WIDTH-1:0] top_max,
  input  logic                   hit,
  output logic                   busy,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] removed,
  output mts_pkg::err_t          err,
  output logic [CNT_W-1:0]       count,
  output logic [IDX_W-1:0]       last_idx,
  output mts_pkg::cell_ctl_t     ctl,
  output logic [VALUE_WIDTH-1:0] push_max
);
  import mts_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] steps;
  logic [CNT_W-1:0] count_m1;
  logic             full;
  logic             empty;

  assign busy     = (state != ST_IDLE);
  assign full     = (count == CNT_W'(STACK_DEPTH));
  assign empty    = (count == '0);
  assign count_m1 = count - 1'b1;
  assign last_idx = count_m1[IDX_W-1:0];
  assign push_max = (empty || $signed(push_val) >= $signed(top_max)) ? push_val : top_max;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && func == FUNC_POPMAX && !empty) begin
          state_next = ST_HUNT;
        end
      end
      ST_HUNT: begin
        if (hit) begin
          state_next = (steps == '0) ? ST_IDLE : ST_FIX;
        end
      end
      ST_FIX: begin
        if (steps == IDX_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.op  = OP_HOLD;
    ctl.hit = hit;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (func)
            FUNC_PUSH:   ctl.op = full  ? OP_HOLD : OP_PUSH;
            FUNC_POP:    ctl.op = empty ? OP_HOLD : OP_POP;
            FUNC_POPMAX: ctl.op = empty ? OP_HOLD : OP_ARM;
            default:     ctl.op = OP_HOLD;
          endcase
        end
      end
      ST_HUNT: ctl.op = OP_HUNT;
      ST_FIX:  ctl.op = OP_FIX;
      default: ctl.op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
      err   <= ERR_OK;
      steps <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            removed <= '0;
            err     <= ERR_OK;
            unique case (func)
              FUNC_PUSH: begin
                done <= 1'b1;
                if (full) begin
                  err <= ERR_OVER;
                end else begin
                  count <= count + 1'b1;
                end
              end
              FUNC_POP: begin
                done <= 1'b1;
                if (empty) begin
                  err <= ERR_UNDER;
                end else begin
                  count   <= count_m1;
                  removed <= top_val;
                end
              end
              FUNC_POPMAX: begin
                steps <= '0;
                if (empty) begin
                  err  <= ERR_UNDER;
                  done <= 1'b1;
                end else begin
                  removed <= top_max;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        ST_HUNT: begin
          if (hit) begin
            count <= count_m1;
            if (steps == '0) begin
              done <= 1'b1;
            end
          end else begin
            steps <= steps + 1'b1;
          end
        end
        ST_FIX: begin
          steps <= steps - 1'b1;
          if (steps == IDX_W'(1)) begin
            done <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ src/max_tracking_stack.sv @@
// push and pop: result strobe in the cycle after the request is taken
// pop maximum: the hunt token walks down one cell a cycle to the topmost entry
// equal to the maximum, and that entry is removed; then the running maxima
// ripple back up one cell a cycle, and the strobe follows the last step
// busy is low in the strobe cycle, so the next request can be taken there
// synchronous reset empties the stack; stored values are not cleared
// -----------------------------------------------------------------------------
// max_tracking_stack
// bounded stack of signed values with running maximum, built as a cell chain
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module max_tracking_stack #(
  parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = mts_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         func,
  input  logic signed [31:0]                 push_value,
  output logic                               done,
  output logic signed [31:0]                 removed_value,
  output logic signed [31:0]                 top_value,
  output logic signed [31:0]                 max_value,
  output logic [$clog2(STACK_DEPTH+1)-1:0]   entry_count,
  output logic                               is_empty,
  output logic [1:0]                         error_code
);
  import mts_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);

  logic [VALUE_WIDTH-1:0] push_val;
  logic [VALUE_WIDTH-1:0] push_max;
  logic [VALUE_WIDTH-1:0] removed;
  logic [CNT_W-1:0]       count;
  logic [IDX_W-1:0]       last_idx;
  err_t                   err;
  cell_ctl_t              ctl;
  logic                   hit_any;

  logic [VALUE_WIDTH-1:0] cval [STACK_DEPTH];
  logic [VALUE_WIDTH-1:0] cmax [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] ctok;
  logic [STACK_DEPTH-1:0] chit;

  assign push_val = VALUE_WIDTH'(push_value);
  assign hit_any  = |chit;

  mts_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .CNT_W       (CNT_W),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .func     (func),
    .push_val (push_val),
    .top_val  (cval[0]),
    .top_max  (cmax[0]),
    .hit      (hit_any),
    .busy     (busy),
    .done     (done),
    .removed  (removed),
    .err      (err),
    .count    (count),
    .last_idx (last_idx),
    .ctl      (ctl),
    .push_max (push_max)
  );

  for (genvar j = 0; j < STACK_DEPTH; j++) begin : g_cell
    logic [VALUE_WIDTH-1:0] a_val;
    logic [VALUE_WIDTH-1:0] a_max;
    logic [VALUE_WIDTH-1:0] b_val;
    logic [VALUE_WIDTH-1:0] b_max;
    logic                   a_tok;

    if (j == 0) begin : g_top
      assign a_val = push_val;
      assign a_max = push_max;
      assign a_tok = 1'b0;
    end else begin : g_mid
      assign a_val = cval[j-1];
      assign a_max = cmax[j-1];
      assign a_tok = ctok[j-1];
    end

    if (j == STACK_DEPTH - 1) begin : g_end
      assign b_val = '0;
      assign b_max = '0;
    end else begin : g_link
      assign b_val = cval[j+1];
      assign b_max = cmax[j+1];
    end

    mts_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX_W       (IDX_W),
      .IDX         (j)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .last_idx  (last_idx),
      .target    (removed),
      .above_val (a_val),
      .above_max (a_max),
      .below_val (b_val),
      .below_max (b_max),
      .tok_above (a_tok),
      .val       (cval[j]),
      .max       (cmax[j]),
      .tok       (ctok[j]),
      .hit       (chit[j])
    );
  end

  assign is_empty      = (count == '0);
  assign entry_count   = count;
  assign error_code    = err;
  assign removed_value = 32'(removed);
  assign top_value     = is_empty ? 32'sd0 : 32'(cval[0]);
  assign max_value     = is_empty ? 32'sd0 : 32'(cmax[0]);

endmodule

@@ src/mts_checker.sv @@
// -----------------------------------------------------------------------------
// mts_checker
// port level checks of the max tracking stack, bound to the top level
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "max_tracking_stack_defines.svh"

module mts_checker #(
  parameter int CNT_W = 5
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [CNT_W-1:0]   entry_count,
  input logic               is_empty,
  input logic [1:0]         error_code,
  input logic signed [31:0] removed_value
);

  // every taken request is either answered or in progress next cycle
  `MTS_ASSERT_NEXT(a_req_progress, clk, rst, start && !busy, done || busy)
  // a result frees the block for the next request
  `MTS_ASSERT_NOW(a_done_free, clk, rst, done, !busy)
  // empty flag agrees with the count
  `MTS_ASSERT_NOW(a_empty_count, clk, rst, done, is_empty == (entry_count == '0))
  // failed requests remove nothing
  `MTS_ASSERT_NOW(a_err_nothing, clk, rst, done && error_code != 2'd0, removed_value == 32'sd0)

endmodule

bind max_tracking_stack mts_checker #(
  .CNT_W ($clog2(STACK_DEPTH + 1))
) u_mts_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .entry_count   (entry_count),
  .is_empty      (is_empty),
  .error_code    (error_code),
  .removed_value (removed_value)
);

@@ sim/max_tracking_stack_tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// max_tracking_stack_tb
// Drives push, pop and pop-max requests, including underflow, overflow, equal
// maxima and the unused selector. A scoreboard keeps its own copy of the stack
// and checks every strobed result field by field.
// -----------------------------------------------------------------------------

module max_tracking_stack_tb;
  import mts_pkg::*;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic signed [31:0] removed;
    logic signed [31:0] top;
    logic signed [31:0] maxv;
    logic [4:0]         count;
    logic               empty;
    err_t               err;
  } stack_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] func = FUNC_PUSH;
  logic signed [31:0] push_value = '0;
  logic busy;
  logic done;
  logic signed [31:0] removed_value;
  logic signed [31:0] top_value;
  logic signed [31:0] max_value;
  logic [4:0] entry_count;
  logic is_empty;
  logic [1:0] error_code;

  logic signed [31:0] shadow_vals [DEPTH];
  logic signed [31:0] shadow_maxes [DEPTH];
  int shadow_fill = 0;
  stack_result_t pending_results [$];
  int fail_count = 0;
  int cycle_count = 0;

  max_tracking_stack dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .push_value    (push_value),
    .done          (done),
    .removed_value (removed_value),
    .top_value     (top_value),
    .max_value     (max_value),
    .entry_count   (entry_count),
    .is_empty      (is_empty),
    .error_code    (error_code)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // running maximum for an entry placed at position pos, counted from the bottom
  function automatic logic signed [31:0] prefix_max(int pos, logic signed [31:0] v);
    if (pos == 0) return v;
    return (v >= shadow_maxes[pos-1]) ? v : shadow_maxes[pos-1];
  endfunction

  function automatic stack_result_t apply_stack_op(logic [1:0] f, logic signed [31:0] v);
    stack_result_t r;
    int n;
    int pos;
    logic signed [31:0] m;
    n = shadow_fill;
    r.removed = '0;
    r.err = ERR_OK;
    if (f == FUNC_PUSH) begin
      if (n >= DEPTH) begin
        r.err = ERR_OVER;
      end else begin
        shadow_vals[n] = v;
        shadow_maxes[n] = prefix_max(n, v);
        n++;
      end
    end else if (f == FUNC_POP) begin
      if (n == 0) begin
        r.err = ERR_UNDER;
      end else begin
        n--;
        r.removed = shadow_vals[n];
      end
    end else if (f == FUNC_POPMAX) begin
      if (n == 0) begin
        r.err = ERR_UNDER;
      end else begin
        m = shadow_maxes[n-1];
        pos = n - 1;
        while (pos > 0 && shadow_vals[pos] != m) pos--;
        r.removed = shadow_vals[pos];
        for (int i = pos; i + 1 < n; i++) begin
          shadow_vals[i] = shadow_vals[i+1];
          shadow_maxes[i] = prefix_max(i, shadow_vals[i]);
        end
        n--;
      end
    end
    shadow_fill = n;
    r.top = (n != 0) ? shadow_vals[n-1] : '0;
    r.maxv = (n != 0) ? shadow_maxes[n-1] : '0;
    r.count = n[4:0];
    r.empty = (n == 0);
    return r;
  endfunction

  // caller is at a rising edge; start stays high until the request is taken
  task automatic send_request(logic [1:0] f, logic signed [31:0] v);
    start <= 1'b1;
    func <= f;
    push_value <= v;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_stack_op(f, v));
  endtask

  task automatic idle_for(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 7))
      0, 1: v = $signed($urandom_range(0, 4)) - 2;
      2: begin
        case ($urandom_range(0, 3))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = '0;
          default: v = -1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] pick_func(int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return FUNC_UNUSED;
    if (roll < push_pct) return FUNC_PUSH;
    return ($urandom_range(0, 1) != 0) ? FUNC_POP : FUNC_POPMAX;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    stack_result_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with no request outstanding");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("removed_value", exp_r.removed, removed_value);
        check_field("top_value", exp_r.top, top_value);
        check_field("max_value", exp_r.maxv, max_value);
        check_field("entry_count", 32'(exp_r.count), 32'(entry_count));
        check_field("is_empty", 32'(exp_r.empty), 32'(is_empty));
        check_field("error_code", 32'(exp_r.err), 32'(error_code));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_empty_removal();
    send_request(FUNC_POP, 32'sd5);
    send_request(FUNC_POPMAX, -32'sd7);
    send_request(FUNC_UNUSED, VAL_MAX);
  endtask

  // fills to the limit with duplicated maxima buried deep, then overflows
  task automatic test_fill_and_overflow();
    logic signed [31:0] fill_vals [DEPTH];
    fill_vals = '{VAL_MIN, VAL_MAX, -32'sd1, 32'sd0, 32'sh5555_5555, 32'shaaaa_aaaa,
                  32'sd1, 32'sh7fff_fffe, -32'sd2, VAL_MAX, 32'sh0f0f_0f0f,
                  32'sh8000_0001, 32'sd100, -32'sd100, 32'sh1234_5678, 32'shfedc_ba98};
    for (int i = 0; i < DEPTH; i++) send_request(FUNC_PUSH, fill_vals[i]);
    send_request(FUNC_PUSH, 32'sd42);
    send_request(FUNC_UNUSED, 32'sd3);
  endtask

  task automatic test_equal_maxima();
    send_request(FUNC_POPMAX, '0);
    send_request(FUNC_POPMAX, -32'sd1);
    send_request(FUNC_POP, VAL_MIN);
  endtask

  task automatic test_random_ops(int n_items);
    int push_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 80;
          1: push_pct = 50;
          default: push_pct = 20;
        endcase
      end
      if ($urandom_range(0, 7) == 0) idle_for($urandom_range(1, 19));
      send_request(pick_func(push_pct), pick_value());
    end
  endtask

  task automatic test_drain_pause();
    wait_results_drained();
    idle_for($urandom_range(1, 19));
  endtask

  task automatic test_back_to_back(int n_items);
    for (int i = 0; i < n_items; i++) begin
      send_request(pick_func((i / 30) % 2 == 0 ? 75 : 25), pick_value());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_removal();
    test_fill_and_overflow();
    test_equal_maxima();
    test_random_ops(280);
    test_drain_pause();
    test_random_ops(270);
    test_back_to_back(150);
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ max_tracking_stack.f @@
+incdir+src
src/mts_pkg.sv
src/mts_cell.sv
src/mts_ctrl.sv
src/max_tracking_stack.sv
src/mts_checker.sv
sim/max_tracking_stack_tb.sv
